/* hw/rtl/rgb888_pixel_format_converter_macros.svh */
// ----------------------------------------------------------------------------
// RGB888 pixel format converter assertion macros
// Shared concurrent check forms used by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef RGB888_PIXEL_FORMAT_CONVERTER_MACROS_SVH
`define RGB888_PIXEL_FORMAT_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpfc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpfc: next-cycle check failed");

`endif

/* hw/rtl/rpfc_pkg.sv */
// ----------------------------------------------------------------------------
// RGB888 pixel format converter package
// Widths, codes, coefficients, stage structs and the RGB565 helper function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpfc_pkg;

    // Frame geometry limits.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);

    // Field and register widths.
    localparam int COMP_W   = 8;
    localparam int SUM_W    = COMP_W + 1;
    localparam int LINE_W   = 3 * SUM_W;
    localparam int COL_W    = 11;
    localparam int ROW_W    = 12;
    localparam int FMT_W    = 3;
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 13;
    localparam int DATA_W   = 32;
    localparam int CDATA_W  = 16;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // Output queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Divide by 1000: numerators stay below 2^18, so a 19-bit reciprocal
    // with a 28-bit shift gives the exact quotient.
    localparam int NUM_W       = 18;
    localparam int RECIP_W     = 19;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;

    // BT.601 coefficients, scaled by 1000, with the half-up rounding term folded in.
    localparam int LUMA_BIAS   = 16000 + 500;
    localparam int CHROMA_BIAS = 128000 + 500;
    localparam int Y_R  = 257;
    localparam int Y_G  = 504;
    localparam int Y_B  = 98;
    localparam int CB_R = 148;
    localparam int CB_G = 291;
    localparam int CB_B = 439;
    localparam int CR_R = 439;
    localparam int CR_G = 368;
    localparam int CR_B = 71;

    // Output formats; codes 5 to 7 behave as XRGB32.
    typedef enum logic [FMT_W-1:0] {
        FMT_XRGB32 = 3'd0,
        FMT_XBGR32 = 3'd1,
        FMT_RGB565 = 3'd2,
        FMT_NV12   = 3'd3,
        FMT_NV21   = 3'd4
    } fmt_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_FORMAT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    // Pixel as it leaves the front stage.
    typedef struct packed {
        logic               valid;
        logic [FMT_W-1:0]   fmt;
        logic [COMP_W-1:0]  red;
        logic [COMP_W-1:0]  green;
        logic [COMP_W-1:0]  blue;
        logic [SUM_W-1:0]   sum_red;
        logic [SUM_W-1:0]   sum_green;
        logic [SUM_W-1:0]   sum_blue;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               chroma;
    } front_t;

    // Line store access for one pixel.
    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [LINE_AW-1:0] addr;
        logic [LINE_W-1:0]  wdata;
    } line_req_t;

    // One queued pixel with its optional chroma pair.
    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [CDATA_W-1:0] cdata;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               chroma;
    } result_t;

    // Output queue status.
    typedef struct packed {
        logic [FIFO_AW:0] occupancy;
        logic             empty;
    } fifo_stat_t;

    // RGB565 with round-up on the next lower bit and saturation.
    function automatic logic [15:0] to565(
        input logic [COMP_W-1:0] r,
        input logic [COMP_W-1:0] g,
        input logic [COMP_W-1:0] b
    );
        logic [5:0] r5;
        logic [6:0] g6;
        logic [5:0] b5;
        r5 = {1'b0, r[7:3]} + {5'b0, r[2]};
        g6 = {1'b0, g[7:2]} + {6'b0, g[1]};
        b5 = {1'b0, b[7:3]} + {5'b0, b[2]};
        if (r5[5])
        begin
            r5 = 6'd31;
        end
        if (g6[6])
        begin
            g6 = 7'd63;
        end
        if (b5[5])
        begin
            b5 = 6'd31;
        end
        return {r5[4:0], g6[5:0], b5[4:0]};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rpfc_if.sv */
// ----------------------------------------------------------------------------
// RGB888 pixel format converter stream interfaces
// Valid/ready channels for input pixels and output results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Input pixel channel.
interface rpfc_pixel_if
    import rpfc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// Output result channel.
interface rpfc_result_if
    import rpfc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              plane;
    logic [DATA_W-1:0] pixel_data;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic              last;

    modport source (output valid, output plane, output pixel_data, output column,
                    output row, output last, input ready);
    modport sink   (input valid, input plane, input pixel_data, input column,
                    input row, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rgb888_pixel_format_converter.sv */
// ----------------------------------------------------------------------------
// RGB888 pixel format converter
// Converts a raster stream of RGB888 pixels to XRGB32, XBGR32, RGB565, NV12
// or NV21 output words.
// Pixels arrive on pixel_in in raster order, top row first; the block counts
// column and row itself from frame_width and frame_height. Each transfer on
// result_out carries one result. Every pixel gives one result on plane 0; in
// NV12 and NV21 each odd-row, odd-column pixel adds a chroma pair on plane 1,
// built from the 2x2 block and the line store of pair sums from the row above.
// A pixel's first result follows the front, stage 2 and stage 3 registers and
// the output queue. One pixel is accepted per cycle while the queue has room;
// one result is sent per cycle while the receiver is ready, so on odd NV rows
// two pixels give three results. An eight-pixel output queue sits between
// the sides: a stalled receiver fills it, and pixel_in.ready drops only when
// it is full. Reset clears counters, held pixel and queue and loads XRGB32,
// 640 x 480; no clearing pass runs on the line store. Configuration is written
// over APB only while no pixel is in flight; the user's duty, never checked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rgb888_pixel_format_converter_macros.svh"

module rgb888_pixel_format_converter
    import rpfc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    rpfc_pixel_if.sink             pixel_in,
    rpfc_result_if.source          result_out
);

    logic [FMT_W-1:0]    fmt_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    logic                cfg_write;
    logic                accept;
    logic                in_ready;
    line_req_t           line_req;
    logic [LINE_W-1:0]   line_rd_data;
    front_t              s1;
    logic                wr_valid;
    result_t             wr_result;
    fifo_stat_t          fifo_stat;
    logic                chroma_out;
    logic                pair_open;

    // Configuration registers.
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_XRGB32;
            width_reg  <= WIDTH_W'(640);
            height_reg <= HEIGHT_W'(480);
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_FORMAT:
                begin
                    fmt_reg <= pwdata[FMT_W-1:0];
                end
                REG_WIDTH:
                begin
                    width_reg <= pwdata[WIDTH_W-1:0];
                end
                REG_HEIGHT:
                begin
                    height_reg <= pwdata[HEIGHT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_FORMAT:
            begin
                prdata = APB_DW'(fmt_reg);
            end
            REG_WIDTH:
            begin
                prdata = APB_DW'(width_reg);
            end
            REG_HEIGHT:
            begin
                prdata = APB_DW'(height_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // Input transfer.
    assign accept         = pixel_in.valid && in_ready;
    assign pixel_in.ready = in_ready;

    rpfc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .red          (pixel_in.red),
        .green        (pixel_in.green),
        .blue         (pixel_in.blue),
        .fmt          (fmt_reg),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .line_req     (line_req),
        .s1           (s1)
    );

    rpfc_line_store u_line_store (
        .clk      (clk),
        .line_req (line_req),
        .rd_data  (line_rd_data)
    );

    rpfc_math u_math (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1        (s1),
        .rd_data   (line_rd_data),
        .wr_valid  (wr_valid),
        .wr_result (wr_result)
    );

    rpfc_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (accept),
        .wr_valid   (wr_valid),
        .wr_result  (wr_result),
        .out_ready  (result_out.ready),
        .in_ready   (in_ready),
        .out_valid  (result_out.valid),
        .out_plane  (result_out.plane),
        .out_data   (result_out.pixel_data),
        .out_column (result_out.column),
        .out_row    (result_out.row),
        .out_last   (result_out.last),
        .stat       (fifo_stat)
    );

    // Output conditions used by the checks below.
    assign chroma_out = result_out.valid && result_out.plane;
    assign pair_open  = result_out.valid && result_out.ready && !result_out.last;

    // A chroma pair is always the final result of its pixel.
    `RPFC_ASSERT_IMPLY(a_chroma_last, clk, rst_n, chroma_out, result_out.last)

    // After a non-final transfer the chroma pair of the same pixel follows.
    `RPFC_ASSERT_NEXT(a_pair_follows, clk, rst_n, pair_open, chroma_out)

    // An accepted pixel is counted as outstanding in the next cycle.
    `RPFC_ASSERT_NEXT(a_occ_tracks, clk, rst_n, accept, fifo_stat.occupancy != '0)

endmodule

`default_nettype wire

/* hw/rtl/rpfc_line_store.sv */
// ----------------------------------------------------------------------------
// RGB888 pixel format converter line store
// Synchronous memory of horizontal pair sums from the last even row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpfc_line_store
    import rpfc_pkg::*;
(
    input  wire logic              clk,
    input  wire line_req_t         line_req,
    output logic [LINE_W-1:0]      rd_data
);

    logic [LINE_W-1:0] mem [LINE_DEPTH];
    logic [LINE_W-1:0] rd_data_reg;

    // Writes come from even rows and reads from odd rows, so one pixel
    // never reads and writes the same entry and no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (line_req.wr_en)
        begin
            mem[line_req.addr] <= line_req.wdata;
        end
        if (line_req.rd_en)
        begin
            rd_data_reg <= mem[line_req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/rpfc_front.sv */
// ----------------------------------------------------------------------------
// RGB888 pixel format converter front stage
// Column and row counters, held pixel, pair sums and line store access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpfc_front
    import rpfc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [COMP_W-1:0]   red,
    input  wire logic [COMP_W-1:0]   green,
    input  wire logic [COMP_W-1:0]   blue,
    input  wire logic [FMT_W-1:0]    fmt,
    input  wire logic [WIDTH_W-1:0]  frame_width,
    input  wire logic [HEIGHT_W-1:0] frame_height,
    output line_req_t                line_req,
    output front_t                   s1
);

    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [3*COMP_W-1:0] held_reg, held_next;
    front_t              s1_reg, s1_next;

    logic [WIDTH_W-1:0]  width_c;
    logic [HEIGHT_W-1:0] height_c;
    logic [WIDTH_W-1:0]  col_inc;
    logic [HEIGHT_W-1:0] row_inc;
    logic [SUM_W-1:0]    sum_r, sum_g, sum_b;
    logic                is_nv;

    // Frame size clamped to the supported range.
    always_comb
    begin
        if (frame_width < WIDTH_W'(2))
        begin
            width_c = WIDTH_W'(2);
        end
        else if ({1'b0, frame_width} > (WIDTH_W + 1)'(MAX_WIDTH))
        begin
            width_c = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            width_c = frame_width;
        end

        if (frame_height < HEIGHT_W'(2))
        begin
            height_c = HEIGHT_W'(2);
        end
        else if ({1'b0, frame_height} > (HEIGHT_W + 1)'(MAX_HEIGHT))
        begin
            height_c = HEIGHT_W'(MAX_HEIGHT);
        end
        else
        begin
            height_c = frame_height;
        end
    end

    // Raster counters, held pixel and horizontal pair sums.
    always_comb
    begin
        col_inc = {1'b0, col_reg} + WIDTH_W'(1);
        row_inc = {1'b0, row_reg} + HEIGHT_W'(1);
        sum_r   = {1'b0, held_reg[23:16]} + {1'b0, red};
        sum_g   = {1'b0, held_reg[15:8]}  + {1'b0, green};
        sum_b   = {1'b0, held_reg[7:0]}   + {1'b0, blue};
        is_nv   = (fmt == FMT_NV12) || (fmt == FMT_NV21);

        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        if (accept)
        begin
            if (col_inc >= width_c)
            begin
                col_next = '0;
                row_next = (row_inc >= height_c) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
            if (!col_reg[0])
            begin
                held_next = {red, green, blue};
            end
        end

        line_req.addr  = col_reg[LINE_AW:1];
        line_req.wdata = {sum_r, sum_g, sum_b};
        line_req.wr_en = accept && col_reg[0] && !row_reg[0];
        line_req.rd_en = accept && col_reg[0] && row_reg[0];

        s1_next.valid     = accept;
        s1_next.fmt       = fmt;
        s1_next.red       = red;
        s1_next.green     = green;
        s1_next.blue      = blue;
        s1_next.sum_red   = sum_r;
        s1_next.sum_green = sum_g;
        s1_next.sum_blue  = sum_b;
        s1_next.col       = col_reg;
        s1_next.row       = row_reg;
        s1_next.chroma    = col_reg[0] && row_reg[0] && is_nv;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
            s1_reg   <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
            s1_reg   <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

`default_nettype wire

/* hw/rtl/rpfc_math.sv */
// ----------------------------------------------------------------------------
// RGB888 pixel format converter arithmetic pipeline
// Packing, 2x2 averaging, BT.601 sums and reciprocal divide by 1000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpfc_math
    import rpfc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire front_t            s1,
    input  wire logic [LINE_W-1:0] rd_data,
    output logic                   wr_valid,
    output result_t                wr_result
);

    typedef struct packed {
        logic              valid;
        logic [FMT_W-1:0]  fmt;
        logic [DATA_W-1:0] packed_data;
        logic [NUM_W-1:0]  luma_num;
        logic [NUM_W-1:0]  cb_num;
        logic [NUM_W-1:0]  cr_num;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              chroma;
    } num_stage_t;

    typedef struct packed {
        logic              valid;
        logic [FMT_W-1:0]  fmt;
        logic [DATA_W-1:0] packed_data;
        logic [PROD_W-1:0] luma_prod;
        logic [PROD_W-1:0] cb_prod;
        logic [PROD_W-1:0] cr_prod;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              chroma;
    } prod_stage_t;

    num_stage_t  s2_reg, s2_next;
    prod_stage_t s3_reg, s3_next;

    logic [SUM_W+1:0]  quad_r, quad_g, quad_b;
    logic [COMP_W-1:0] avg_r, avg_g, avg_b;
    logic [COMP_W-1:0] luma_q, cb_q, cr_q;

    // Stage 2: 2x2 average, weighted sums and the packed RGB formats.
    always_comb
    begin
        quad_r = {2'b0, s1.sum_red}   + {2'b0, rd_data[3*SUM_W-1:2*SUM_W]} + (SUM_W + 2)'(2);
        quad_g = {2'b0, s1.sum_green} + {2'b0, rd_data[2*SUM_W-1:SUM_W]}   + (SUM_W + 2)'(2);
        quad_b = {2'b0, s1.sum_blue}  + {2'b0, rd_data[SUM_W-1:0]}         + (SUM_W + 2)'(2);
        // Four components plus two stay below 1024, so the average fits a byte.
        avg_r  = quad_r[COMP_W+1:2];
        avg_g  = quad_g[COMP_W+1:2];
        avg_b  = quad_b[COMP_W+1:2];

        s2_next.valid  = s1.valid;
        s2_next.fmt    = s1.fmt;
        s2_next.col    = s1.col;
        s2_next.row    = s1.row;
        s2_next.chroma = s1.chroma;

        // All three numerators stay positive and below 2^18.
        s2_next.luma_num = NUM_W'(LUMA_BIAS)
                         + NUM_W'(Y_R) * NUM_W'(s1.red)
                         + NUM_W'(Y_G) * NUM_W'(s1.green)
                         + NUM_W'(Y_B) * NUM_W'(s1.blue);
        s2_next.cb_num   = NUM_W'(CHROMA_BIAS)
                         + NUM_W'(CB_B) * NUM_W'(avg_b)
                         - NUM_W'(CB_R) * NUM_W'(avg_r)
                         - NUM_W'(CB_G) * NUM_W'(avg_g);
        s2_next.cr_num   = NUM_W'(CHROMA_BIAS)
                         + NUM_W'(CR_R) * NUM_W'(avg_r)
                         - NUM_W'(CR_G) * NUM_W'(avg_g)
                         - NUM_W'(CR_B) * NUM_W'(avg_b);

        case (s1.fmt)
            FMT_XBGR32:
            begin
                s2_next.packed_data = {8'h00, s1.blue, s1.green, s1.red};
            end
            FMT_RGB565:
            begin
                s2_next.packed_data = {16'h0000, to565(s1.red, s1.green, s1.blue)};
            end
            default:
            begin
                s2_next.packed_data = {8'h00, s1.red, s1.green, s1.blue};
            end
        endcase
    end

    // Stage 3: multiply by the reciprocal of 1000.
    always_comb
    begin
        s3_next.valid       = s2_reg.valid;
        s3_next.fmt         = s2_reg.fmt;
        s3_next.packed_data = s2_reg.packed_data;
        s3_next.col         = s2_reg.col;
        s3_next.row         = s2_reg.row;
        s3_next.chroma      = s2_reg.chroma;
        s3_next.luma_prod   = s2_reg.luma_num * RECIP_1000;
        s3_next.cb_prod     = s2_reg.cb_num * RECIP_1000;
        s3_next.cr_prod     = s2_reg.cr_num * RECIP_1000;
    end

    // Quotients and final packing into the output queue entry.
    always_comb
    begin
        luma_q = s3_reg.luma_prod[RECIP_SHIFT +: COMP_W];
        cb_q   = s3_reg.cb_prod[RECIP_SHIFT +: COMP_W];
        cr_q   = s3_reg.cr_prod[RECIP_SHIFT +: COMP_W];

        wr_valid         = s3_reg.valid;
        wr_result.col    = s3_reg.col;
        wr_result.row    = s3_reg.row;
        wr_result.chroma = s3_reg.chroma;
        case (s3_reg.fmt)
            FMT_NV12:
            begin
                wr_result.data  = {24'h000000, luma_q};
                wr_result.cdata = {cr_q, cb_q};
            end
            FMT_NV21:
            begin
                wr_result.data  = {24'h000000, luma_q};
                wr_result.cdata = {cb_q, cr_q};
            end
            default:
            begin
                wr_result.data  = s3_reg.packed_data;
                wr_result.cdata = {cr_q, cb_q};
            end
        endcase
    end

    // Pipeline registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rpfc_out_fifo.sv */
// ----------------------------------------------------------------------------
// RGB888 pixel format converter output queue
// Holds finished pixels and splits each into one or two result transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpfc_out_fifo
    import rpfc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_accept,
    input  wire logic          wr_valid,
    input  wire result_t       wr_result,
    input  wire logic          out_ready,
    output logic               in_ready,
    output logic               out_valid,
    output logic               out_plane,
    output logic [DATA_W-1:0]  out_data,
    output logic [COL_W-1:0]   out_column,
    output logic [ROW_W-1:0]   out_row,
    output logic               out_last,
    output fifo_stat_t         stat
);

    result_t          entry_reg [FIFO_DEPTH];
    logic [FIFO_AW:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0] occ_reg, occ_next;
    logic             phase_reg, phase_next;

    result_t          head;
    logic             empty;
    logic             xfer;
    logic             pop;

    // Head entry and the transfer that retires it.
    always_comb
    begin
        head  = entry_reg[rd_ptr_reg[FIFO_AW-1:0]];
        empty = (wr_ptr_reg == rd_ptr_reg);
        xfer  = !empty && out_ready;
        pop   = xfer && (phase_reg || !head.chroma);
    end

    // Occupancy counts every pixel accepted and not yet fully sent, so
    // pixels in the arithmetic pipeline always have a queue slot waiting.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (FIFO_AW + 1)'(wr_valid);
        rd_ptr_next = rd_ptr_reg + (FIFO_AW + 1)'(pop);
        occ_next    = occ_reg + (FIFO_AW + 1)'(in_accept) - (FIFO_AW + 1)'(pop);
        phase_next  = phase_reg;
        if (xfer)
        begin
            phase_next = !pop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
            phase_reg  <= phase_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            entry_reg[wr_ptr_reg[FIFO_AW-1:0]] <= wr_result;
        end
    end

    // The first transfer carries the pixel word, the second the chroma pair.
    always_comb
    begin
        in_ready   = (occ_reg != (FIFO_AW + 1)'(FIFO_DEPTH));
        out_valid  = !empty;
        out_plane  = phase_reg;
        out_last   = phase_reg || !head.chroma;
        if (phase_reg)
        begin
            out_data   = {16'h0000, head.cdata};
            out_column = head.col - COL_W'(1);
            out_row    = head.row - ROW_W'(1);
        end
        else
        begin
            out_data   = head.data;
            out_column = head.col;
            out_row    = head.row;
        end
        stat.occupancy = occ_reg;
        stat.empty     = empty;
    end

endmodule

`default_nettype wire
